// ===== rtl/http_request_byte_parser_defines.svh =====
// ----------------------------------------------------------------------------
// HTTP request byte parser - assertion macros
// Shared clocked assertion forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef HTTP_REQUEST_BYTE_PARSER_DEFINES_SVH
`define HTTP_REQUEST_BYTE_PARSER_DEFINES_SVH

// Property sampled on the rising clock, off while reset is asserted.
`define HRBP_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define HRBP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/hrbp_pkg.sv =====
// ----------------------------------------------------------------------------
// HTTP request byte parser - package
// Phase, header and result codes, token caps and string match helpers.
// ----------------------------------------------------------------------------
package hrbp_pkg;

    localparam int METHOD_LEN_MAX_DEF  = 16;
    localparam int PATH_LEN_MAX_DEF    = 64;
    localparam int VERSION_LEN_MAX_DEF = 16;
    localparam int FIELD_LEN_MAX_DEF   = 64;
    localparam int VALUE_LEN_MAX_DEF   = 128;

    typedef enum logic [2:0] {
        PH_METHOD  = 3'd0,
        PH_PATH    = 3'd1,
        PH_VERSION = 3'd2,
        PH_FIELD   = 3'd3,
        PH_VALUE   = 3'd4,
        PH_DEAD    = 3'd6
    } t_phase;

    typedef enum logic [1:0] {
        HDR_NONE       = 2'd0,
        HDR_UPG        = 2'd1,
        HDR_CONNECTION = 2'd2,
        HDR_KEY        = 2'd3
    } t_hdr;

    typedef enum logic [1:0] {
        EV_NONE    = 2'd0,
        EV_DONE    = 2'd1,
        EV_UPGRADE = 2'd2
    } t_event;

    typedef enum logic [2:0] {
        RESP_NONE      = 3'd0,
        RESP_OK        = 3'd1,
        RESP_SWITCH    = 3'd2,
        RESP_BAD       = 3'd3,
        RESP_NOT_FOUND = 3'd4
    } t_resp;

    typedef struct packed {
        t_resp  resp;
        t_event ev;
    } t_result;

    localparam logic [7:0] CHR_CR    = 8'h0D;
    localparam logic [7:0] CHR_LF    = 8'h0A;
    localparam logic [7:0] CHR_SP    = 8'h20;
    localparam logic [7:0] CHR_COLON = 8'h3A;

    // Candidate mask bits for header names.
    localparam int CAND_UPG = 0;
    localparam int CAND_CON = 1;
    localparam int CAND_KEY = 2;

    localparam int SOCK_LEN = 7;
    localparam int UPG_LEN  = 7;
    localparam int CON_LEN  = 10;
    localparam int KEY_LEN  = 17;
    localparam int WS_LEN   = 9;

    localparam logic [SOCK_LEN*8-1:0] SOCK_STR = "/socket";
    localparam logic [UPG_LEN*8-1:0]  UPG_STR  = "upgrade";
    localparam logic [CON_LEN*8-1:0]  CON_STR  = "connection";
    localparam logic [KEY_LEN*8-1:0]  KEY_STR  = "sec-websocket-key";
    localparam logic [WS_LEN*8-1:0]   WS_STR   = "websocket";

    function automatic logic [7:0] f_lower(input logic [7:0] c);
        logic [7:0] l;
        l = c;
        if (c >= 8'h41 && c <= 8'h5A) begin
            l = c + 8'd32;
        end
        return l;
    endfunction

    // Character at position pos matches; false past the end of the string.
    function automatic logic f_hit_sock(input logic [7:0] pos, input logic [7:0] c);
        logic hit;
        hit = 1'b0;
        if (pos < 8'(SOCK_LEN)) begin
            hit = (c == SOCK_STR[(SOCK_LEN - 1 - int'(pos)) * 8 +: 8]);
        end
        return hit;
    endfunction

    function automatic logic f_hit_upg(input logic [7:0] pos, input logic [7:0] c);
        logic hit;
        hit = 1'b0;
        if (pos < 8'(UPG_LEN)) begin
            hit = (c == UPG_STR[(UPG_LEN - 1 - int'(pos)) * 8 +: 8]);
        end
        return hit;
    endfunction

    function automatic logic f_hit_con(input logic [7:0] pos, input logic [7:0] c);
        logic hit;
        hit = 1'b0;
        if (pos < 8'(CON_LEN)) begin
            hit = (c == CON_STR[(CON_LEN - 1 - int'(pos)) * 8 +: 8]);
        end
        return hit;
    endfunction

    function automatic logic f_hit_key(input logic [7:0] pos, input logic [7:0] c);
        logic hit;
        hit = 1'b0;
        if (pos < 8'(KEY_LEN)) begin
            hit = (c == KEY_STR[(KEY_LEN - 1 - int'(pos)) * 8 +: 8]);
        end
        return hit;
    endfunction

    function automatic logic f_hit_ws(input logic [7:0] pos, input logic [7:0] c);
        logic hit;
        hit = 1'b0;
        if (pos < 8'(WS_LEN)) begin
            hit = (c == WS_STR[(WS_LEN - 1 - int'(pos)) * 8 +: 8]);
        end
        return hit;
    endfunction

endpackage

// ===== rtl/hrbp_core.sv =====
// ----------------------------------------------------------------------------
// HTTP request byte parser - parse core
// Per-byte phase walk, token caps, path/name/value matchers and header flags.
// ----------------------------------------------------------------------------
module hrbp_core #(
    parameter int METHOD_LEN_MAX  = hrbp_pkg::METHOD_LEN_MAX_DEF,
    parameter int PATH_LEN_MAX    = hrbp_pkg::PATH_LEN_MAX_DEF,
    parameter int VERSION_LEN_MAX = hrbp_pkg::VERSION_LEN_MAX_DEF,
    parameter int FIELD_LEN_MAX   = hrbp_pkg::FIELD_LEN_MAX_DEF,
    parameter int VALUE_LEN_MAX   = hrbp_pkg::VALUE_LEN_MAX_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic [7:0]        i_byte,
    output hrbp_pkg::t_result o_result
);

    hrbp_pkg::t_phase r_phase, n_phase;
    logic [7:0]       r_cnt, n_cnt;
    logic [2:0]       r_path_prog, n_path_prog;
    logic             r_path_miss, n_path_miss;
    logic [2:0]       r_cand, n_cand;
    hrbp_pkg::t_hdr   r_hdr, n_hdr;
    logic [3:0]       r_ndl_prog, n_ndl_prog;
    logic             r_ndl_found, n_ndl_found;
    logic             r_upgrade_ok, n_upgrade_ok;
    logic             r_connection_ok, n_connection_ok;
    logic             r_key_seen, n_key_seen;

    logic [7:0] low_c;
    logic       skip;
    logic [7:0] ndl_len;
    logic       ndl_hit;
    logic       ndl_first;
    logic [3:0] ndl_next;

    assign low_c = hrbp_pkg::f_lower(i_byte);
    assign skip  = (r_phase <= hrbp_pkg::PH_VALUE) &&
                   (i_byte == hrbp_pkg::CHR_CR ||
                    (i_byte == hrbp_pkg::CHR_SP && r_cnt == 8'd0));

    // Needle matcher: "websocket" under Upgrade, "upgrade" under Connection.
    always_comb begin
        if (r_hdr == hrbp_pkg::HDR_UPG) begin
            ndl_len   = 8'(hrbp_pkg::WS_LEN);
            ndl_hit   = hrbp_pkg::f_hit_ws({4'd0, r_ndl_prog}, low_c);
            ndl_first = hrbp_pkg::f_hit_ws(8'd0, low_c);
        end else begin
            ndl_len   = 8'(hrbp_pkg::UPG_LEN);
            ndl_hit   = hrbp_pkg::f_hit_upg({4'd0, r_ndl_prog}, low_c);
            ndl_first = hrbp_pkg::f_hit_upg(8'd0, low_c);
        end
        if (ndl_hit) begin
            ndl_next = r_ndl_prog + 4'd1;
        end else begin
            ndl_next = ndl_first ? 4'd1 : 4'd0;
        end
    end

    always_comb begin
        n_phase         = r_phase;
        n_cnt           = r_cnt;
        n_path_prog     = r_path_prog;
        n_path_miss     = r_path_miss;
        n_cand          = r_cand;
        n_hdr           = r_hdr;
        n_ndl_prog      = r_ndl_prog;
        n_ndl_found     = r_ndl_found;
        n_upgrade_ok    = r_upgrade_ok;
        n_connection_ok = r_connection_ok;
        n_key_seen      = r_key_seen;
        o_result.ev     = hrbp_pkg::EV_NONE;
        o_result.resp   = hrbp_pkg::RESP_NONE;

        if (!skip) begin
            unique case (r_phase)
                hrbp_pkg::PH_METHOD: begin
                    if (i_byte == hrbp_pkg::CHR_SP) begin
                        n_phase     = hrbp_pkg::PH_PATH;
                        n_cnt       = 8'd0;
                        n_path_prog = 3'd0;
                        n_path_miss = 1'b0;
                    end else if (r_cnt < 8'(METHOD_LEN_MAX)) begin
                        n_cnt = r_cnt + 8'd1;
                    end
                end
                hrbp_pkg::PH_PATH: begin
                    if (i_byte == hrbp_pkg::CHR_SP) begin
                        n_phase = hrbp_pkg::PH_VERSION;
                        n_cnt   = 8'd0;
                    end else if (r_cnt < 8'(PATH_LEN_MAX)) begin
                        if (!hrbp_pkg::f_hit_sock(r_cnt, i_byte)) begin
                            n_path_miss = 1'b1;
                        end
                        if (r_path_prog != 3'd7) begin
                            n_path_prog = r_path_prog + 3'd1;
                        end
                        n_cnt = r_cnt + 8'd1;
                    end
                end
                hrbp_pkg::PH_VERSION: begin
                    if (i_byte == hrbp_pkg::CHR_LF) begin
                        n_phase = hrbp_pkg::PH_FIELD;
                        n_cnt   = 8'd0;
                        n_cand  = 3'b111;
                        n_hdr   = hrbp_pkg::HDR_NONE;
                    end else if (r_cnt < 8'(VERSION_LEN_MAX)) begin
                        n_cnt = r_cnt + 8'd1;
                    end
                end
                hrbp_pkg::PH_FIELD: begin
                    if (i_byte == hrbp_pkg::CHR_LF) begin
                        // Blank line or a line without a colon: end of request.
                        o_result.ev = hrbp_pkg::EV_DONE;
                        if (!r_path_miss && r_path_prog == 3'd1) begin
                            o_result.resp = hrbp_pkg::RESP_OK;
                        end else if (!r_path_miss && r_path_prog == 3'd7) begin
                            if (r_connection_ok && r_upgrade_ok && r_key_seen) begin
                                o_result.ev   = hrbp_pkg::EV_UPGRADE;
                                o_result.resp = hrbp_pkg::RESP_SWITCH;
                            end else begin
                                o_result.resp = hrbp_pkg::RESP_BAD;
                            end
                        end else begin
                            o_result.resp = hrbp_pkg::RESP_NOT_FOUND;
                        end
                        n_phase = (o_result.ev == hrbp_pkg::EV_UPGRADE) ?
                                  hrbp_pkg::PH_DEAD : hrbp_pkg::PH_METHOD;
                        n_cnt   = 8'd0;
                        n_cand  = 3'b111;
                        n_hdr   = hrbp_pkg::HDR_NONE;
                    end else if (i_byte == hrbp_pkg::CHR_COLON) begin
                        priority if (r_cand[hrbp_pkg::CAND_KEY] &&
                                     r_cnt == 8'(hrbp_pkg::KEY_LEN)) begin
                            n_hdr = hrbp_pkg::HDR_KEY;
                        end else if (r_cand[hrbp_pkg::CAND_CON] &&
                                     r_cnt == 8'(hrbp_pkg::CON_LEN)) begin
                            n_hdr = hrbp_pkg::HDR_CONNECTION;
                        end else if (r_cand[hrbp_pkg::CAND_UPG] &&
                                     r_cnt == 8'(hrbp_pkg::UPG_LEN)) begin
                            n_hdr = hrbp_pkg::HDR_UPG;
                        end else begin
                            n_hdr = hrbp_pkg::HDR_NONE;
                        end
                        n_phase     = hrbp_pkg::PH_VALUE;
                        n_cnt       = 8'd0;
                        n_ndl_prog  = 4'd0;
                        n_ndl_found = 1'b0;
                    end else if (r_cnt < 8'(FIELD_LEN_MAX)) begin
                        n_cand[hrbp_pkg::CAND_UPG] = r_cand[hrbp_pkg::CAND_UPG] &
                            hrbp_pkg::f_hit_upg(r_cnt, low_c);
                        n_cand[hrbp_pkg::CAND_CON] = r_cand[hrbp_pkg::CAND_CON] &
                            hrbp_pkg::f_hit_con(r_cnt, low_c);
                        n_cand[hrbp_pkg::CAND_KEY] = r_cand[hrbp_pkg::CAND_KEY] &
                            hrbp_pkg::f_hit_key(r_cnt, low_c);
                        n_cnt = r_cnt + 8'd1;
                    end
                end
                hrbp_pkg::PH_VALUE: begin
                    if (i_byte == hrbp_pkg::CHR_LF) begin
                        unique case (r_hdr)
                            hrbp_pkg::HDR_UPG:        n_upgrade_ok    = r_ndl_found;
                            hrbp_pkg::HDR_CONNECTION: n_connection_ok = r_ndl_found;
                            hrbp_pkg::HDR_KEY:        n_key_seen      = 1'b1;
                            default: ;
                        endcase
                        n_phase = hrbp_pkg::PH_FIELD;
                        n_cnt   = 8'd0;
                        n_cand  = 3'b111;
                        n_hdr   = hrbp_pkg::HDR_NONE;
                    end else if (r_cnt < 8'(VALUE_LEN_MAX)) begin
                        if ((r_hdr == hrbp_pkg::HDR_UPG ||
                             r_hdr == hrbp_pkg::HDR_CONNECTION) && !r_ndl_found) begin
                            if ({4'd0, ndl_next} >= ndl_len) begin
                                n_ndl_found = 1'b1;
                                n_ndl_prog  = 4'd0;
                            end else begin
                                n_ndl_prog = ndl_next;
                            end
                        end
                        n_cnt = r_cnt + 8'd1;
                    end
                end
                default: ;  // dead after upgrade: drop every byte
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase         <= hrbp_pkg::PH_METHOD;
            r_cnt           <= 8'd0;
            r_path_prog     <= 3'd0;
            r_path_miss     <= 1'b0;
            r_cand          <= 3'b111;
            r_hdr           <= hrbp_pkg::HDR_NONE;
            r_ndl_prog      <= 4'd0;
            r_ndl_found     <= 1'b0;
            r_upgrade_ok    <= 1'b0;
            r_connection_ok <= 1'b0;
            r_key_seen      <= 1'b0;
        end else if (i_en) begin
            r_phase         <= n_phase;
            r_cnt           <= n_cnt;
            r_path_prog     <= n_path_prog;
            r_path_miss     <= n_path_miss;
            r_cand          <= n_cand;
            r_hdr           <= n_hdr;
            r_ndl_prog      <= n_ndl_prog;
            r_ndl_found     <= n_ndl_found;
            r_upgrade_ok    <= n_upgrade_ok;
            r_connection_ok <= n_connection_ok;
            r_key_seen      <= n_key_seen;
        end
    end

endmodule

// ===== rtl/http_request_byte_parser.sv =====
// Output: a result is registered and appears in the cycle after its byte is transferred.
// Throughput: one byte per cycle; the single output register refills in the
//   cycle its result is taken, so input ready is low only while a result stalls.
// Reset: synchronous, active low; returns to the method phase, clears the
//   header flags and the dead state, and empties the output register.
// ----------------------------------------------------------------------------
// HTTP request byte parser - top level
// Stream wrapper: byte in, one {event, response} result out per byte.
// ----------------------------------------------------------------------------
module http_request_byte_parser #(
    parameter int METHOD_LEN_MAX  = hrbp_pkg::METHOD_LEN_MAX_DEF,
    parameter int PATH_LEN_MAX    = hrbp_pkg::PATH_LEN_MAX_DEF,
    parameter int VERSION_LEN_MAX = hrbp_pkg::VERSION_LEN_MAX_DEF,
    parameter int FIELD_LEN_MAX   = hrbp_pkg::FIELD_LEN_MAX_DEF,
    parameter int VALUE_LEN_MAX   = hrbp_pkg::VALUE_LEN_MAX_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,   // [7:0] byte_in
    output logic       o_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    output logic [7:0] o_m_axis_tdata    // [1:0] event_res, [4:2] response, [7:5] zero
);

    hrbp_pkg::t_result res;
    hrbp_pkg::t_result r_res;
    logic              r_valid;
    logic              take;

    assign o_s_axis_tready = !r_valid || i_m_axis_tready;
    assign take            = i_s_axis_tvalid && o_s_axis_tready;

    hrbp_core #(
        .METHOD_LEN_MAX  (METHOD_LEN_MAX),
        .PATH_LEN_MAX    (PATH_LEN_MAX),
        .VERSION_LEN_MAX (VERSION_LEN_MAX),
        .FIELD_LEN_MAX   (FIELD_LEN_MAX),
        .VALUE_LEN_MAX   (VALUE_LEN_MAX)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (take),
        .i_byte   (i_s_axis_tdata),
        .o_result (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (take) begin
            r_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_res <= res;
        end
    end

    assign o_m_axis_tvalid = r_valid;
    assign o_m_axis_tdata  = {3'd0, r_res.resp, r_res.ev};

endmodule

// ===== rtl/hrbp_checker.sv =====
// ----------------------------------------------------------------------------
// HTTP request byte parser - port checker
// Watches the stream ports for result encoding, stall behavior and dead state.
// ----------------------------------------------------------------------------
`include "http_request_byte_parser_defines.svh"

module hrbp_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_tvalid,
    input logic       i_in_tready,
    input logic       i_out_tvalid,
    input logic       i_out_tready,
    input logic [7:0] i_out_tdata
);

    logic       r_dead;
    logic       in_xfer;
    logic       out_stall;
    logic [1:0] out_ev;
    logic [2:0] out_resp;
    logic       out_coded;

    assign in_xfer   = i_in_tvalid && i_in_tready;
    assign out_stall = i_out_tvalid && !i_out_tready;
    assign out_ev    = i_out_tdata[1:0];
    assign out_resp  = i_out_tdata[4:2];

    // Nothing-event goes with no response, upgrade with switch; padding stays zero.
    assign out_coded = ((out_ev == hrbp_pkg::EV_NONE) == (out_resp == hrbp_pkg::RESP_NONE)) &&
                       ((out_ev == hrbp_pkg::EV_UPGRADE) ==
                        (out_resp == hrbp_pkg::RESP_SWITCH)) &&
                       (i_out_tdata[7:5] == 3'd0);

    // Mark the transfer of an upgrade result; nothing may be reported after it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dead <= 1'b0;
        end else if (i_out_tvalid && i_out_tready && out_ev == hrbp_pkg::EV_UPGRADE) begin
            r_dead <= 1'b1;
        end
    end

    `HRBP_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_stall, i_out_tvalid && $stable(i_out_tdata), "held result changed")

    `HRBP_ASSERT(a_ready_when_empty, i_clk, i_rst_n, !i_out_tvalid |-> i_in_tready, "input stalled")

    `HRBP_ASSERT(a_result_pairing, i_clk, i_rst_n, i_out_tvalid |-> out_coded, "bad result code")

    `HRBP_ASSERT(a_silent_after_upgrade, i_clk, i_rst_n, r_dead && i_out_tvalid |-> (out_ev == 2'd0), "late result")

    `HRBP_ASSERT_NEXT(a_result_follows, i_clk, i_rst_n, in_xfer, i_out_tvalid, "byte gave no result")

endmodule

bind http_request_byte_parser hrbp_checker u_hrbp_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_tvalid  (i_s_axis_tvalid),
    .i_in_tready  (o_s_axis_tready),
    .i_out_tvalid (o_m_axis_tvalid),
    .i_out_tready (i_m_axis_tready),
    .i_out_tdata  (o_m_axis_tdata)
);

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// HTTP request byte parser - stream testbench
// Feeds request bytes through the input stream and compares every output
// transfer with a cycle-free model of the parser: short hand-written requests
// first, then random well-formed, truncated and noisy requests under changing
// sender gaps and receiver stalls, ending with a websocket switch and dead
// traffic after it.
// ----------------------------------------------------------------------------
package parser_check_pkg;

    localparam string SOCKET_PATH     = "/socket";
    localparam string UPGRADE_WORD    = "upgrade";
    localparam string CONNECTION_WORD = "connection";
    localparam string KEY_WORD        = "sec-websocket-key";
    localparam string WEBSOCKET_WORD  = "websocket";

    typedef logic [7:0] t_octet_q[$];

    typedef struct {
        hrbp_pkg::t_phase phase;
        logic [7:0]       tok_len;
        logic [2:0]       path_len;
        logic             path_bad;
        logic [2:0]       name_cand;
        hrbp_pkg::t_hdr   hdr;
        logic [3:0]       match_len;
        logic             match_hit;
        logic             upg_ok;
        logic             con_ok;
        logic             key_ok;
    } t_parser_state;

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
    endfunction

    function automatic logic name_hit(input string word, input logic [7:0] pos,
                                      input logic [7:0] lc);
        return pos < word.len() && lc == word[pos];
    endfunction

    function automatic void open_header_line(inout t_parser_state s);
        s.phase     = hrbp_pkg::PH_FIELD;
        s.tok_len   = 8'd0;
        s.name_cand = 3'b111;
        s.hdr       = hrbp_pkg::HDR_NONE;
    endfunction

    // Needles never overlap themselves: restart at the first character.
    function automatic void advance_needle(inout t_parser_state s, input string word,
                                           input logic [7:0] lc);
        if (s.match_hit) begin
            return;
        end
        if (s.match_len < word.len() && lc == word[s.match_len]) begin
            s.match_len++;
        end else begin
            s.match_len = (lc == word[0]) ? 4'd1 : 4'd0;
        end
        if (s.match_len >= word.len()) begin
            s.match_hit = 1'b1;
            s.match_len = 4'd0;
        end
    endfunction

    function automatic hrbp_pkg::t_result parse_step(inout t_parser_state s,
                                                     input logic [7:0] c);
        hrbp_pkg::t_result r;
        logic [7:0]        lc;
        r.ev   = hrbp_pkg::EV_NONE;
        r.resp = hrbp_pkg::RESP_NONE;
        lc     = to_lower(c);
        // Drop carriage returns and spaces ahead of a token while still parsing.
        if (s.phase <= hrbp_pkg::PH_VALUE &&
            (c == hrbp_pkg::CHR_CR || (c == hrbp_pkg::CHR_SP && s.tok_len == 0))) begin
            return r;
        end
        case (s.phase)
            hrbp_pkg::PH_METHOD: begin
                if (c == hrbp_pkg::CHR_SP) begin
                    s.phase    = hrbp_pkg::PH_PATH;
                    s.tok_len  = 8'd0;
                    s.path_len = 3'd0;
                    s.path_bad = 1'b0;
                end else if (s.tok_len < hrbp_pkg::METHOD_LEN_MAX_DEF) begin
                    s.tok_len++;
                end
            end
            hrbp_pkg::PH_PATH: begin
                if (c == hrbp_pkg::CHR_SP) begin
                    s.phase   = hrbp_pkg::PH_VERSION;
                    s.tok_len = 8'd0;
                end else if (s.tok_len < hrbp_pkg::PATH_LEN_MAX_DEF) begin
                    if (s.tok_len >= SOCKET_PATH.len() || c != SOCKET_PATH[s.tok_len]) begin
                        s.path_bad = 1'b1;
                    end
                    if (s.path_len < 3'd7) begin
                        s.path_len++;
                    end
                    s.tok_len++;
                end
            end
            hrbp_pkg::PH_VERSION: begin
                if (c == hrbp_pkg::CHR_LF) begin
                    open_header_line(s);
                end else if (s.tok_len < hrbp_pkg::VERSION_LEN_MAX_DEF) begin
                    s.tok_len++;
                end
            end
            hrbp_pkg::PH_FIELD: begin
                if (c == hrbp_pkg::CHR_LF) begin
                    if (!s.path_bad && s.path_len == 3'd1) begin
                        r.ev   = hrbp_pkg::EV_DONE;
                        r.resp = hrbp_pkg::RESP_OK;
                    end else if (!s.path_bad && s.path_len == 3'd7) begin
                        if (s.con_ok && s.upg_ok && s.key_ok) begin
                            r.ev   = hrbp_pkg::EV_UPGRADE;
                            r.resp = hrbp_pkg::RESP_SWITCH;
                        end else begin
                            r.ev   = hrbp_pkg::EV_DONE;
                            r.resp = hrbp_pkg::RESP_BAD;
                        end
                    end else begin
                        r.ev   = hrbp_pkg::EV_DONE;
                        r.resp = hrbp_pkg::RESP_NOT_FOUND;
                    end
                    s.phase     = (r.ev == hrbp_pkg::EV_UPGRADE) ?
                                  hrbp_pkg::PH_DEAD : hrbp_pkg::PH_METHOD;
                    s.tok_len   = 8'd0;
                    s.name_cand = 3'b111;
                    s.hdr       = hrbp_pkg::HDR_NONE;
                end else if (c == hrbp_pkg::CHR_COLON) begin
                    s.hdr = hrbp_pkg::HDR_NONE;
                    if (s.name_cand[hrbp_pkg::CAND_UPG] &&
                        s.tok_len == UPGRADE_WORD.len()) begin
                        s.hdr = hrbp_pkg::HDR_UPG;
                    end
                    if (s.name_cand[hrbp_pkg::CAND_CON] &&
                        s.tok_len == CONNECTION_WORD.len()) begin
                        s.hdr = hrbp_pkg::HDR_CONNECTION;
                    end
                    if (s.name_cand[hrbp_pkg::CAND_KEY] && s.tok_len == KEY_WORD.len()) begin
                        s.hdr = hrbp_pkg::HDR_KEY;
                    end
                    s.phase     = hrbp_pkg::PH_VALUE;
                    s.tok_len   = 8'd0;
                    s.match_len = 4'd0;
                    s.match_hit = 1'b0;
                end else if (s.tok_len < hrbp_pkg::FIELD_LEN_MAX_DEF) begin
                    if (!name_hit(UPGRADE_WORD, s.tok_len, lc)) begin
                        s.name_cand[hrbp_pkg::CAND_UPG] = 1'b0;
                    end
                    if (!name_hit(CONNECTION_WORD, s.tok_len, lc)) begin
                        s.name_cand[hrbp_pkg::CAND_CON] = 1'b0;
                    end
                    if (!name_hit(KEY_WORD, s.tok_len, lc)) begin
                        s.name_cand[hrbp_pkg::CAND_KEY] = 1'b0;
                    end
                    s.tok_len++;
                end
            end
            hrbp_pkg::PH_VALUE: begin
                if (c == hrbp_pkg::CHR_LF) begin
                    case (s.hdr)
                        hrbp_pkg::HDR_UPG:        s.upg_ok = s.match_hit;
                        hrbp_pkg::HDR_CONNECTION: s.con_ok = s.match_hit;
                        hrbp_pkg::HDR_KEY:        s.key_ok = 1'b1;
                        default: ;
                    endcase
                    open_header_line(s);
                end else if (s.tok_len < hrbp_pkg::VALUE_LEN_MAX_DEF) begin
                    if (s.hdr == hrbp_pkg::HDR_UPG) begin
                        advance_needle(s, WEBSOCKET_WORD, lc);
                    end else if (s.hdr == hrbp_pkg::HDR_CONNECTION) begin
                        advance_needle(s, UPGRADE_WORD, lc);
                    end
                    s.tok_len++;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    class parser_scoreboard;
        t_parser_state     model;
        hrbp_pkg::t_result pending[$];
        int                n_errors;
        int                n_bytes;
        int                n_answers[8];

        function new();
            model = '{hrbp_pkg::PH_METHOD, 8'd0, 3'd0, 1'b0, 3'b111, hrbp_pkg::HDR_NONE,
                      4'd0, 1'b0, 1'b0, 1'b0, 1'b0};
            n_errors = 0;
            n_bytes  = 0;
            foreach (n_answers[i]) begin
                n_answers[i] = 0;
            end
        endfunction

        function void note_byte(input logic [7:0] c);
            pending.push_back(parse_step(model, c));
            n_bytes++;
        endfunction

        task report(input string what);
            $display("[%0t] mismatch: %s", $time, what);
            n_errors++;
        endtask

        task check_result(input logic [7:0] data);
            hrbp_pkg::t_result want;
            if (pending.size() == 0) begin
                report($sformatf("result 0x%02h with no byte waiting for it", data));
                return;
            end
            want = pending.pop_front();
            if (data[1:0] != want.ev) begin
                report($sformatf("event %0d, want %0d", data[1:0], want.ev));
            end
            if (data[4:2] != want.resp) begin
                report($sformatf("response %0d, want %0d", data[4:2], want.resp));
            end
            if (data[7:5] != 3'd0) begin
                report($sformatf("padding bits 0x%0h not zero", data[7:5]));
            end
            if (want.ev != hrbp_pkg::EV_NONE) begin
                n_answers[int'(want.resp)]++;
            end
        endtask
    endclass
endpackage

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HOLD_CYCLES   = 400;
    localparam int QUIET_LIMIT   = 2000;
    localparam int BYTES_PER_MIX = 160;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_s_axis_tvalid;
    logic       o_s_axis_tready;
    logic [7:0] i_s_axis_tdata;     // [7:0] byte_in
    logic       o_m_axis_tvalid;
    logic       i_m_axis_tready;
    logic [7:0] o_m_axis_tdata;     // [1:0] event_res, [4:2] response, [7:5] zero

    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    int hold_epoch     = 0;

    parser_check_pkg::t_octet_q         req;
    parser_check_pkg::parser_scoreboard sb = new();

    http_request_byte_parser dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic void add_text(input string s, input bit mix_case);
        logic [7:0] c;
        logic [7:0] lc;
        for (int i = 0; i < s.len(); i++) begin
            c  = s[i];
            lc = parser_check_pkg::to_lower(c);
            if (mix_case && lc >= 8'h61 && lc <= 8'h7A && $urandom_range(1)) begin
                c = c ^ 8'h20;
            end
            req.push_back(c);
        end
    endfunction

    function automatic void add_random(input int n);
        repeat (n) req.push_back(8'($urandom_range(8'h21, 8'h7E)));
    endfunction

    function automatic void add_eol();
        if ($urandom_range(1)) begin
            req.push_back(hrbp_pkg::CHR_CR);
        end
        req.push_back(hrbp_pkg::CHR_LF);
    endfunction

    function automatic void compose_request();
        int pick;
        int cut;
        req.delete();
        pick = $urandom_range(99);
        if (pick < 8) begin
            repeat ($urandom_range(1, 12)) req.push_back(8'($urandom_range(255)));
            return;
        end
        if ($urandom_range(9) == 0) begin
            req.push_back(hrbp_pkg::CHR_SP);
            req.push_back(hrbp_pkg::CHR_CR);
        end
        case ($urandom_range(4))
            0: add_text("GET", 0);
            1: add_text("POST", 0);
            2: add_random($urandom_range(1, 5));
            3: add_random($urandom_range(15, 20));
            default: add_text("get", 1);
        endcase
        req.push_back(hrbp_pkg::CHR_SP);
        if ($urandom_range(3) == 0) begin
            req.push_back(hrbp_pkg::CHR_SP);
        end
        case ($urandom_range(9))
            0, 1, 2: add_text("/", 0);
            3, 4: add_text(parser_check_pkg::SOCKET_PATH, 0);
            5: add_text("/socke", 0);
            6: add_text("/sockets", 0);
            7: add_text("/Socket", 0);
            8: begin
                add_text("/", 0);
                add_random($urandom_range(1, 6));
            end
            default: begin
                add_text(parser_check_pkg::SOCKET_PATH, 0);
                add_random($urandom_range(55, 70));
            end
        endcase
        req.push_back(hrbp_pkg::CHR_SP);
        case ($urandom_range(5))
            0: ;
            1: add_random($urandom_range(14, 20));
            default: add_text("HTTP/1.1", 0);
        endcase
        add_eol();
        repeat ($urandom_range(0, 4)) begin
            if ($urandom_range(11) == 0) begin
                // header line with no colon ends the request early
                add_random($urandom_range(1, 8));
                add_eol();
            end else begin
                case ($urandom_range(11))
                    0, 1: add_text("Upgrade", 1);
                    2, 3: add_text("Connection", 1);
                    4, 5: add_text("Sec-WebSocket-Key", 1);
                    6: add_text("Upgrades", 0);
                    7: add_text("Connectio", 0);
                    8: add_random($urandom_range(1, 10));
                    9: begin
                        add_text("Connection", 0);
                        add_random($urandom_range(55, 70));
                    end
                    10: add_text("Sec-WebSocket-Key-", 0);
                    default: ;
                endcase
                req.push_back(hrbp_pkg::CHR_COLON);
                repeat ($urandom_range(0, 2)) req.push_back(hrbp_pkg::CHR_SP);
                case ($urandom_range(11))
                    0, 1: add_text(parser_check_pkg::WEBSOCKET_WORD, 1);
                    2, 3: add_text("keep-alive, Upgrade", 1);
                    4: add_text("webwebsocket", 0);
                    5: add_text("websocke", 0);
                    6: add_text("upupgrade", 0);
                    7: add_text("upgrad", 0);
                    8: add_random($urandom_range(0, 12));
                    9: begin
                        add_random($urandom_range(120, 135));
                        add_text(parser_check_pkg::WEBSOCKET_WORD, 0);
                    end
                    default: add_text("dGhlIHNhbXBsZQ==", 0);
                endcase
                add_eol();
            end
        end
        add_eol();
        if (pick < 16) begin
            cut = $urandom_range(1, req.size() - 1);
            while (req.size() > cut) void'(req.pop_back());
        end
    endfunction

    task automatic send_byte(input logic [7:0] c);
        if (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < src_idle_pct) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= c;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        sb.note_byte(c);
    endtask

    task automatic send_queue();
        foreach (req[i]) begin
            send_byte(req[i]);
        end
    endtask

    // A switch to websocket kills the parser until reset, so keep it for the end.
    task automatic send_safe_request();
        parser_check_pkg::t_parser_state probe;
        hrbp_pkg::t_result               r;
        bit                              hazard;
        int                              tries;
        hazard = 1'b1;
        tries  = 0;
        while (hazard && tries < 100) begin
            compose_request();
            probe  = sb.model;
            hazard = 1'b0;
            foreach (req[i]) begin
                r = parser_check_pkg::parse_step(probe, req[i]);
                if (r.ev == hrbp_pkg::EV_UPGRADE) begin
                    hazard = 1'b1;
                end
            end
            tries++;
        end
        if (!hazard) begin
            send_queue();
        end
    endtask

    initial begin : sink
        int hold_left;
        int seen_epoch;
        hold_left  = 0;
        seen_epoch = 0;
        i_m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
                sb.check_result(o_m_axis_tdata);
            end
            if (hold_epoch != seen_epoch) begin
                seen_epoch = hold_epoch;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_m_axis_tready <= 1'b0;
            end else begin
                i_m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (i_s_axis_tvalid && o_s_axis_tready) ||
                (o_m_axis_tvalid && i_m_axis_tready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("watchdog: no transfer for %0d cycles", QUIET_LIMIT);
        $display("*** FAILED ***");
        $finish;
    end

    initial begin : stimulus
        int quota;
        int rounds;
        int drain;
        i_rst_n         <= 1'b0;
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tdata  <= 8'h00;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Dropped space and carriage return, zero and all-ones bytes, root path.
        req.delete();
        req.push_back(hrbp_pkg::CHR_SP);
        req.push_back(hrbp_pkg::CHR_CR);
        req.push_back(8'h00);
        add_text(" / ", 0);
        req.push_back(8'hFF);
        req.push_back(hrbp_pkg::CHR_LF);
        req.push_back(hrbp_pkg::CHR_LF);
        // Socket path, header line without colon, then an unknown path.
        add_text("A /socket x", 0);
        req.push_back(hrbp_pkg::CHR_LF);
        add_text("ab", 0);
        req.push_back(hrbp_pkg::CHR_LF);
        add_text("B /x y", 0);
        req.push_back(hrbp_pkg::CHR_LF);
        req.push_back(hrbp_pkg::CHR_LF);
        send_queue();

        for (int mix = 0; mix < 4; mix++) begin
            case (mix)
                0: begin
                    src_idle_pct   = 0;
                    sink_stall_pct = 0;
                    hold_epoch++;
                end
                1: begin
                    src_idle_pct   = 59;
                    sink_stall_pct = 0;
                end
                2: begin
                    src_idle_pct   = 0;
                    sink_stall_pct = 59;
                end
                default: begin
                    src_idle_pct   = 31;
                    sink_stall_pct = 31;
                end
            endcase
            quota  = sb.n_bytes + BYTES_PER_MIX;
            rounds = 0;
            while (sb.n_bytes < quota && rounds < 500) begin
                send_safe_request();
                rounds++;
            end
        end

        // Get back to the start of a request line before the switch.
        rounds = 0;
        while ((sb.model.phase != hrbp_pkg::PH_METHOD || sb.model.tok_len != 0) &&
               rounds < 50) begin
            send_safe_request();
            rounds++;
        end
        req.delete();
        add_text("GET /socket HTTP/1.1", 0);
        add_eol();
        add_text("Upgrade: websocket", 0);
        add_eol();
        add_text("Connection: Upgrade", 0);
        add_eol();
        add_text("Sec-WebSocket-Key: dGhlIHNhbXBsZQ==", 0);
        add_eol();
        add_eol();
        // Everything past the switch must be ignored.
        add_text("GET / HTTP/1.1", 0);
        add_eol();
        add_eol();
        repeat (40) req.push_back(8'($urandom_range(255)));
        send_queue();
        i_s_axis_tvalid <= 1'b0;

        drain = 0;
        while (sb.pending.size() != 0 && drain < 1000) begin
            @(posedge i_clk);
            drain++;
        end
        repeat (4) @(posedge i_clk);
        if (sb.pending.size() != 0) begin
            sb.report($sformatf("%0d results never arrived", sb.pending.size()));
        end

        $display("Sent %0d request bytes across four gap/stall mixes and a %0d-cycle output hold",
                 sb.n_bytes, HOLD_CYCLES);
        $display("Answers: %0d ok, %0d bad, %0d not found, %0d switched; %0d mismatches",
                 sb.n_answers[hrbp_pkg::RESP_OK], sb.n_answers[hrbp_pkg::RESP_BAD],
                 sb.n_answers[hrbp_pkg::RESP_NOT_FOUND], sb.n_answers[hrbp_pkg::RESP_SWITCH],
                 sb.n_errors);
        if (sb.n_errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/hrbp_pkg.sv
rtl/hrbp_core.sv
rtl/http_request_byte_parser.sv
rtl/hrbp_checker.sv
sim/testbench.sv
